/* hw/rtl/wcs_pkg.sv */
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared types, phase/event codes and reset constants for the wash cycle
// sequencer.
// ----------------------------------------------------------------------------
package wcs_pkg;

  // Reset budgets and default counter width
  localparam int unsigned TIMER_WIDTH_DEF = 16;
  localparam logic [15:0] WASH_TICKS_RST  = 16'd30;
  localparam logic [15:0] SPIN_TICKS_RST  = 16'd20;

  // Configuration register indexes
  localparam logic CFG_WASH_TICKS = 1'b0;
  localparam logic CFG_SPIN_TICKS = 1'b1;

  // Event codes (tick and unused codes fall through as plain ticks)
  localparam logic [3:0] EV_START   = 4'd0;
  localparam logic [3:0] EV_FULL    = 4'd1;
  localparam logic [3:0] EV_WASHED  = 4'd2;
  localparam logic [3:0] EV_DRAINED = 4'd3;
  localparam logic [3:0] EV_SPUN    = 4'd4;
  localparam logic [3:0] EV_PAUSE   = 4'd5;
  localparam logic [3:0] EV_RESUME  = 4'd6;
  localparam logic [3:0] EV_STOP    = 4'd7;
  localparam logic [3:0] EV_ERROR   = 4'd8;
  localparam logic [3:0] EV_RESET   = 4'd9;

  // Phase codes as seen on the result channel
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_FILL  = 3'd1;
  localparam logic [2:0] PH_WASH  = 3'd2;
  localparam logic [2:0] PH_DRAIN = 3'd3;
  localparam logic [2:0] PH_SPIN  = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;
  localparam logic [2:0] PH_PAUSE = 3'd6;
  localparam logic [2:0] PH_ERROR = 3'd7;

  // Motor speed codes
  localparam logic [1:0] MOTOR_STOP = 2'd0;
  localparam logic [1:0] MOTOR_WASH = 2'd1;
  localparam logic [1:0] MOTOR_SPIN = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_FILL  = 8'b0000_0010,
    ST_WASH  = 8'b0000_0100,
    ST_DRAIN = 8'b0000_1000,
    ST_SPIN  = 8'b0001_0000,
    ST_DONE  = 8'b0010_0000,
    ST_PAUSE = 8'b0100_0000,
    ST_ERROR = 8'b1000_0000
  } state_t;

  function automatic logic [2:0] phase_code(input state_t st);
    logic [2:0] code;
    case (st)
      ST_IDLE:  code = PH_IDLE;
      ST_FILL:  code = PH_FILL;
      ST_WASH:  code = PH_WASH;
      ST_DRAIN: code = PH_DRAIN;
      ST_SPIN:  code = PH_SPIN;
      ST_DONE:  code = PH_DONE;
      ST_PAUSE: code = PH_PAUSE;
      ST_ERROR: code = PH_ERROR;
      default:  code = PH_IDLE;
    endcase
    return code;
  endfunction

endpackage

/* hw/rtl/wash_cycle_sequencer.sv */
// ----------------------------------------------------------------------------
// wash_cycle_sequencer
// Event-driven washer controller: eight phases, wash/spin tick budgets,
// actuator levels and one-request pulses for beep and error display.
// ----------------------------------------------------------------------------
//
//  Channel  Dir   Handshake          Payload
//  in       in    in_valid/in_stall  event_req[3:0], door_sensor
//  out      out   out_valid/out_stall phase[2:0], door_locked, water_valve_open,
//                                     drain_valve_open, motor_speed[1:0],
//                                     beep_pulse, error_pulse, changed
//  cfg      in    cfg_write          cfg_index, cfg_data[15:0]
//
// One request per cycle while no full result is stalled: the phase step (event
// decode plus both down-counters) settles between the state registers and a
// single result register, and the result is valid in the cycle after accept.
// in_stall is high only while the result register is full and stalled, so a
// new request is taken in the same cycle the previous result leaves.
// Synchronous reset returns to idle, all actuators off, budgets 30 and 20.
//
module wash_cycle_sequencer
  import wcs_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = TIMER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  event_req,
  input  logic        door_sensor,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  phase,
  output logic        door_locked,
  output logic        water_valve_open,
  output logic        drain_valve_open,
  output logic [1:0]  motor_speed,
  output logic        beep_pulse,
  output logic        error_pulse,
  output logic        changed,
  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers
  logic [15:0] wash_ticks;
  logic [15:0] spin_ticks;

  // Sequencer state
  state_t                 cur_state, cur_state_next;
  state_t                 saved_state, saved_state_next;
  logic [TIMER_WIDTH-1:0] wash_count, wash_count_next;
  logic [TIMER_WIDTH-1:0] spin_count, spin_count_next;
  logic                   lock_level, lock_level_next;
  logic                   water_drive, water_drive_next;
  logic                   drain_drive, drain_drive_next;
  logic [1:0]             motor_mode, motor_mode_next;
  logic                   beep_next, error_next, move;

  logic                   accept;
  state_t                 target;
  logic [TIMER_WIDTH-1:0] wash_dec, spin_dec;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Counters saturate at zero
  assign wash_dec = (wash_count != '0) ? wash_count - TIMER_WIDTH'(1) : wash_count;
  assign spin_dec = (spin_count != '0) ? spin_count - TIMER_WIDTH'(1) : spin_count;

  always_comb begin
    cur_state_next   = cur_state;
    saved_state_next = saved_state;
    wash_count_next  = wash_count;
    spin_count_next  = spin_count;
    lock_level_next  = lock_level;
    water_drive_next = water_drive;
    drain_drive_next = drain_drive;
    motor_mode_next  = motor_mode;
    beep_next        = 1'b0;
    error_next       = 1'b0;
    move             = 1'b0;
    target           = cur_state;

    // Transition decode; countdown runs before the event is looked at
    case (cur_state)
      ST_IDLE, ST_DONE: begin
        if (event_req == EV_START && !door_sensor) begin
          move = 1'b1; target = ST_FILL;
        end
      end
      ST_FILL: begin
        if (event_req == EV_FULL) begin
          move = 1'b1; target = ST_WASH;
        end else if (event_req == EV_PAUSE) begin
          move = 1'b1; target = ST_PAUSE;
        end else if (event_req == EV_ERROR) begin
          move = 1'b1; target = ST_ERROR;
        end else if (event_req == EV_STOP) begin
          move = 1'b1; target = ST_DRAIN;
        end
      end
      ST_WASH: begin
        wash_count_next = wash_dec;
        if (event_req == EV_WASHED || wash_dec == '0) begin
          move = 1'b1; target = ST_DRAIN;
        end else if (event_req == EV_PAUSE) begin
          move = 1'b1; target = ST_PAUSE;
        end else if (event_req == EV_ERROR) begin
          move = 1'b1; target = ST_ERROR;
        end else if (event_req == EV_STOP) begin
          move = 1'b1; target = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (event_req == EV_DRAINED) begin
          move = 1'b1; target = ST_SPIN;
        end else if (event_req == EV_ERROR) begin
          move = 1'b1; target = ST_ERROR;
        end else if (event_req == EV_STOP) begin
          move = 1'b1; target = ST_DONE;
        end
      end
      ST_SPIN: begin
        spin_count_next = spin_dec;
        if (event_req == EV_SPUN || spin_dec == '0) begin
          move = 1'b1; target = ST_DONE;
        end else if (event_req == EV_ERROR) begin
          move = 1'b1; target = ST_ERROR;
        end else if (event_req == EV_STOP) begin
          move = 1'b1; target = ST_DONE;
        end
      end
      ST_PAUSE: begin
        if (event_req == EV_RESUME) begin
          move = 1'b1; target = saved_state;
        end else if (event_req == EV_STOP) begin
          move = 1'b1; target = ST_IDLE;
        end
      end
      ST_ERROR: begin
        if (event_req == EV_RESET) begin
          move = 1'b1; target = ST_IDLE;
        end
      end
      default: begin
        move = 1'b1; target = ST_ERROR;
      end
    endcase

    if (move) begin
      // exit actions of the phase being left
      case (cur_state)
        ST_FILL:  water_drive_next = 1'b0;
        ST_WASH:  motor_mode_next  = MOTOR_STOP;
        ST_DRAIN: drain_drive_next = 1'b0;
        ST_SPIN:  motor_mode_next  = MOTOR_STOP;
        default:  ;
      endcase

      cur_state_next = target;

      // entry actions of the new phase
      case (target)
        ST_IDLE: lock_level_next = 1'b0;  // valves and motor keep their levels
        ST_FILL: begin
          lock_level_next  = 1'b1;
          water_drive_next = 1'b1;
        end
        ST_WASH: begin
          wash_count_next = TIMER_WIDTH'(wash_ticks);
          motor_mode_next = MOTOR_WASH;
        end
        ST_DRAIN: drain_drive_next = 1'b1;
        ST_SPIN: begin
          spin_count_next = TIMER_WIDTH'(spin_ticks);
          motor_mode_next = MOTOR_SPIN;
        end
        ST_DONE: begin
          lock_level_next = 1'b0;
          beep_next       = 1'b1;
        end
        ST_PAUSE: begin
          saved_state_next = cur_state;  // phase that was interrupted
          motor_mode_next  = MOTOR_STOP;
          water_drive_next = 1'b0;
        end
        default: begin  // error
          motor_mode_next  = MOTOR_STOP;
          water_drive_next = 1'b0;
          drain_drive_next = 1'b0;
          error_next       = 1'b1;
        end
      endcase
    end
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wash_ticks <= WASH_TICKS_RST;
      spin_ticks <= SPIN_TICKS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WASH_TICKS: wash_ticks <= cfg_data;
        CFG_SPIN_TICKS: spin_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // State update on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state   <= ST_IDLE;
      saved_state <= ST_IDLE;
      wash_count  <= '0;
      spin_count  <= '0;
      lock_level  <= 1'b0;
      water_drive <= 1'b0;
      drain_drive <= 1'b0;
      motor_mode  <= MOTOR_STOP;
    end else if (accept) begin
      cur_state   <= cur_state_next;
      saved_state <= saved_state_next;
      wash_count  <= wash_count_next;
      spin_count  <= spin_count_next;
      lock_level  <= lock_level_next;
      water_drive <= water_drive_next;
      drain_drive <= drain_drive_next;
      motor_mode  <= motor_mode_next;
    end
  end

  // Result register: valid flag is control, payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      phase            <= phase_code(cur_state_next);
      door_locked      <= lock_level_next;
      water_valve_open <= water_drive_next;
      drain_valve_open <= drain_drive_next;
      motor_speed      <= motor_mode_next;
      beep_pulse       <= beep_next;
      error_pulse      <= error_next;
      changed          <= move;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  a_beep_enters_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && beep_pulse) |-> (phase == PH_DONE && changed && !door_locked))
    else $error("beep without entering done");

  a_error_safe: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_pulse) |->
      (phase == PH_ERROR && changed && motor_speed == MOTOR_STOP &&
       !water_valve_open && !drain_valve_open))
    else $error("error entry left an actuator on");

  a_pause_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase == PH_PAUSE) |->
      (motor_speed == MOTOR_STOP && !water_valve_open))
    else $error("motor or water on while paused");
`endif

endmodule
